// ===== design/gbts_pkg.sv =====
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);      // store address width
  localparam int unsigned PW    = $clog2(DEPTH + 1);  // position width, holds DEPTH
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned LEN_W = 11;

  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e              op;
    logic             backward;
    logic             zero_cnt;
    logic [CNT_W-1:0] count;
    logic [CH_W-1:0]  char_in;
    logic [IDX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [CH_W-1:0]  read_char;
    logic [LEN_W-1:0] text_length;
    logic [LEN_W-1:0] cursor;
  } res_t;

endpackage

// ===== design/gbts_front.sv =====
`timescale 1ns / 1ps

module gbts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic              backward_i,
  input  logic [10:0]       count_i,
  input  logic [7:0]        char_in_i,
  input  logic [9:0]        index_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output gbts_pkg::cmd_t    cmd_o
);

  logic           valid_q, valid_d;
  gbts_pkg::cmd_t cmd_q, cmd_d;
  logic           take;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d          = 1'b1;
      cmd_d.op         = gbts_pkg::op_e'(action_i);
      cmd_d.backward   = backward_i;
      cmd_d.count      = count_i;
      cmd_d.char_in    = char_in_i;
      cmd_d.index      = index_i;
      // flag remove or move with nothing to do
      cmd_d.zero_cnt   = (count_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign push_o = valid_q;
  assign cmd_o  = cmd_q;

endmodule

// ===== design/gbts_queue.sv =====
`timescale 1ns / 1ps

module gbts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  gbts_pkg::cmd_t cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output gbts_pkg::cmd_t cmd_o
);

  gbts_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign cmd_o        = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/gbts_back.sv =====
`timescale 1ns / 1ps

module gbts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_o,
  input  gbts_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output gbts_pkg::res_t res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  localparam int unsigned AW = gbts_pkg::AW;
  localparam int unsigned PW = gbts_pkg::PW;

  state_e                      state_q, state_d;
  logic [PW-1:0]               gb_q, gb_d;
  logic [PW-1:0]               gf_q, gf_d;
  gbts_pkg::cmd_t              cmd_q, cmd_d;
  gbts_pkg::status_e           stat_q, stat_d;
  logic [gbts_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic                        pend_q, pend_d;
  logic [AW-1:0]               rp_q, rp_d;
  logic [AW-1:0]               wp_q, wp_d;
  logic                        out_valid_q, out_valid_d;
  gbts_pkg::res_t              out_q, out_d;

  logic [gbts_pkg::CH_W-1:0]   mem [gbts_pkg::DEPTH];
  logic [gbts_pkg::CH_W-1:0]   rdata_q;
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [gbts_pkg::CH_W-1:0]   wdata;

  logic [PW-1:0]               after, len, cnt, idx, phys;
  logic                        over;

  assign after = gbts_pkg::DEPTH_P - gf_q;
  assign len   = gb_q + after;
  assign cnt   = PW'(cmd_q.count);
  assign idx   = PW'(cmd_q.index);
  assign phys  = (idx < gb_q) ? idx : (idx + (gf_q - gb_q));
  // count beyond the text on the chosen side of the gap
  assign over  = cmd_q.backward ? (cnt > gb_q) : (cnt > after);

  always_comb begin
    state_d     = state_q;
    gb_d        = gb_q;
    gf_d        = gf_q;
    cmd_d       = cmd_q;
    stat_d      = stat_q;
    rem_d       = rem_q;
    pend_d      = 1'b0;
    rp_d        = rp_q;
    wp_d        = wp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = wp_q;
    raddr       = rp_q;
    wdata       = rdata_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        stat_d  = gbts_pkg::STAT_DONE;
        state_d = ST_RESP;
        unique case (cmd_q.op)
          gbts_pkg::OP_INSERT: begin
            if (gb_q >= gf_q) begin
              stat_d = gbts_pkg::STAT_FULL;
            end else begin
              we    = 1'b1;
              waddr = gb_q[AW-1:0];
              wdata = cmd_q.char_in;
              gb_d  = gb_q + PW'(1);
            end
          end
          gbts_pkg::OP_REMOVE: begin
            if (over) begin
              stat_d = gbts_pkg::STAT_RANGE;
            end else if (cmd_q.backward) begin
              gb_d = gb_q - cnt;
            end else begin
              gf_d = gf_q + cnt;
            end
          end
          gbts_pkg::OP_MOVE: begin
            if (over) begin
              stat_d = gbts_pkg::STAT_RANGE;
            end else if (!cmd_q.zero_cnt) begin
              rem_d   = cmd_q.count;
              state_d = ST_MOVE;
              if (cmd_q.backward) begin
                rp_d = gb_q[AW-1:0] - AW'(1);
                wp_d = gf_q[AW-1:0] - AW'(1);
                gb_d = gb_q - cnt;
                gf_d = gf_q - cnt;
              end else begin
                rp_d = gf_q[AW-1:0];
                wp_d = gb_q[AW-1:0];
                gb_d = gb_q + cnt;
                gf_d = gf_q + cnt;
              end
            end
          end
          gbts_pkg::OP_READ: begin
            if (idx >= len) begin
              stat_d = gbts_pkg::STAT_RANGE;
            end else begin
              re    = 1'b1;
              raddr = phys[AW-1:0];
            end
          end
          default: stat_d = gbts_pkg::STAT_DONE;
        endcase
      end
      ST_MOVE: begin
        // read one byte ahead, write the byte fetched last cycle
        if (rem_q != '0) begin
          re     = 1'b1;
          raddr  = rp_q;
          rp_d   = cmd_q.backward ? (rp_q - AW'(1)) : (rp_q + AW'(1));
          rem_d  = rem_q - gbts_pkg::CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          state_d = ST_RESP;
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = wp_q;
          wdata = rdata_q;
          wp_d  = cmd_q.backward ? (wp_q - AW'(1)) : (wp_q + AW'(1));
        end
      end
      ST_RESP: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = stat_q;
          out_d.read_char   = (cmd_q.op == gbts_pkg::OP_READ && stat_q == gbts_pkg::STAT_DONE)
                              ? rdata_q : '0;
          out_d.text_length = gbts_pkg::LEN_W'(len);
          out_d.cursor      = gbts_pkg::LEN_W'(gb_q);
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gb_q        <= '0;
      gf_q        <= gbts_pkg::DEPTH_P;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gb_q        <= gb_d;
      gf_q        <= gf_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    stat_q <= stat_d;
    rem_q  <= rem_d;
    rp_q   <= rp_d;
    wp_q   <= wp_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gb_q <= gf_q) else $error("gap begin passed gap finish");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_EXEC || state_q == ST_MOVE))
    else $error("store written outside execution");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result raised without a response step");

  a_move_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && rem_q == '0) |-> pend_q)
    else $error("gap move finished with no trailing write");
`endif

endmodule

// ===== design/gap_buffer_text_store_unit.sv =====
`timescale 1ns / 1ps

// Gap buffer text store: 1024 bytes of text with the cursor at the gap.
// Input channel (s_axis_*): one beat per command. tuser carries the action
// (insert, remove, move gap, read) and the backward flag; tdata carries
// count, the byte to insert and the read index.
// Output channel (m_axis_*): one result beat per command with status,
// byte read, text length and cursor after the command.
// Insert, remove and read pass from the accepted input beat through the
// input register, the queue, the pop into the execution unit, execute
// and respond to a valid result. A gap move adds a copy loop that reads
// one byte per cycle from the single-port-read store and writes it in
// the cycle after. The execution unit handles one command at a time and
// pops the next only after it has registered the last result.
// A two-entry command queue and the input register let the source keep
// sending while a result waits on a stalled receiver; once they fill,
// s_axis_tready drops. The result register holds its beat until taken.
// Reset empties the text (cursor 0, length 0) and drops all pending
// commands and results; the store contents need no clearing.

module gap_buffer_text_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // count[10:0], char_in[18:11], index[28:19], zero pad
  input  logic [2:0]  s_axis_tuser,  // action[1:0], backward[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status[1:0], read_char[9:2], text_length[20:10],
                                     // cursor[31:21]
);

  logic           push, push_ready, pop, pop_valid;
  gbts_pkg::cmd_t front_cmd, queue_cmd;
  gbts_pkg::res_t res;

  gbts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser[1:0]),
    .backward_i   (s_axis_tuser[2]),
    .count_i      (s_axis_tdata[10:0]),
    .char_in_i    (s_axis_tdata[18:11]),
    .index_i      (s_axis_tdata[28:19]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (front_cmd)
  );

  gbts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .cmd_i        (front_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .cmd_o        (queue_cmd)
  );

  gbts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .cmd_i       (queue_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.cursor, res.text_length, res.read_char, res.status};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // count[10:0], char_in[18:11], index[28:19], zero pad
  logic [2:0]  s_axis_tuser;  // action[1:0], backward[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // status[1:0], read_char[9:2], text_length[20:10],
                              // cursor[31:21]

  // Mirror of the text: gap_lo is the cursor, gap_hi the first byte after the gap.
  logic [gbts_pkg::CH_W-1:0] text_mem [gbts_pkg::DEPTH];
  int unsigned               gap_lo = 0;
  int unsigned               gap_hi = gbts_pkg::DEPTH;
  gbts_pkg::res_t            pending_results[$];

  int unsigned fail_count   = 0;
  int unsigned cmd_count    = 0;
  int unsigned result_count = 0;
  int unsigned full_count   = 0;
  int unsigned range_count  = 0;
  int unsigned bytes_copied = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;

  always #4 clk_i = ~clk_i;

  gap_buffer_text_store_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic int unsigned text_len();
    return gap_lo + gbts_pkg::DEPTH - gap_hi;
  endfunction

  // Apply one edit command to the mirror and return the result it must produce.
  function automatic gbts_pkg::res_t edit_text(gbts_pkg::op_e op, logic bwd,
                                               int unsigned cnt,
                                               logic [gbts_pkg::CH_W-1:0] ch,
                                               int unsigned idx);
    gbts_pkg::res_t r;
    int unsigned    tail;
    r.status    = gbts_pkg::STAT_DONE;
    r.read_char = '0;
    tail = gbts_pkg::DEPTH - gap_hi;
    case (op)
      gbts_pkg::OP_INSERT: begin
        if (gap_lo >= gap_hi) begin
          r.status = gbts_pkg::STAT_FULL;
        end else begin
          text_mem[gap_lo] = ch;
          gap_lo++;
        end
      end
      gbts_pkg::OP_REMOVE: begin
        if (cnt > (bwd ? gap_lo : tail)) begin
          r.status = gbts_pkg::STAT_RANGE;
        end else if (bwd) begin
          gap_lo -= cnt;
        end else begin
          gap_hi += cnt;
        end
      end
      gbts_pkg::OP_MOVE: begin
        if (cnt > (bwd ? gap_lo : tail)) begin
          r.status = gbts_pkg::STAT_RANGE;
        end else begin
          bytes_copied += cnt;
          repeat (cnt) begin
            if (bwd) begin
              gap_lo--;
              gap_hi--;
              text_mem[gap_hi] = text_mem[gap_lo];
            end else begin
              text_mem[gap_lo] = text_mem[gap_hi];
              gap_lo++;
              gap_hi++;
            end
          end
        end
      end
      default: begin
        if (idx >= gap_lo + tail) begin
          r.status = gbts_pkg::STAT_RANGE;
        end else if (idx < gap_lo) begin
          r.read_char = text_mem[idx];
        end else begin
          r.read_char = text_mem[idx + gap_hi - gap_lo];
        end
      end
    endcase
    if (r.status == gbts_pkg::STAT_FULL) full_count++;
    if (r.status == gbts_pkg::STAT_RANGE) range_count++;
    r.text_length = gbts_pkg::LEN_W'(text_len());
    r.cursor      = gbts_pkg::LEN_W'(gap_lo);
    return r;
  endfunction

  // Drive one command beat and hold it until accepted.
  task automatic issue_edit(gbts_pkg::op_e op, logic bwd, int unsigned cnt,
                            logic [gbts_pkg::CH_W-1:0] ch, int unsigned idx);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, gbts_pkg::IDX_W'(idx), ch, gbts_pkg::CNT_W'(cnt)};
    s_axis_tuser  <= {bwd, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(edit_text(op, bwd, cnt, ch, idx));
    cmd_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned edit_count(int unsigned side, int unsigned short_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(short_max);
    if (r < 95) return $urandom_range(side);
    return $urandom_range(gbts_pkg::DEPTH);
  endfunction

  function automatic int unsigned text_index();
    if (text_len() != 0 && $urandom_range(99) < 80) return $urandom_range(text_len() - 1);
    return $urandom_range(gbts_pkg::DEPTH - 1);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    gbts_pkg::res_t want;
    gbts_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = gbts_pkg::status_e'(m_axis_tdata[1:0]);
      got.read_char   = m_axis_tdata[9:2];
      got.text_length = m_axis_tdata[20:10];
      got.cursor      = m_axis_tdata[31:21];
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no command pending: expected none, actual %h",
                 $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("read_char", want.read_char, got.read_char);
        check_field("text_length", want.text_length, got.text_length);
        check_field("cursor", want.cursor, got.cursor);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic test_directed_edges();
    // empty text: reads and nonzero counts are out of range, zero counts pass
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b1, gbts_pkg::DEPTH, 8'hFF, gbts_pkg::DEPTH - 1);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b1, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b0, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b1, 1, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b0, 1, 8'h00, 0);
    issue_edit(gbts_pkg::OP_MOVE, 1'b1, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_MOVE, 1'b0, 1, 8'h00, 0);
    issue_edit(gbts_pkg::OP_MOVE, 1'b1, gbts_pkg::DEPTH, 8'h00, 0);
    issue_edit(gbts_pkg::OP_INSERT, 1'b0, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_INSERT, 1'b1, gbts_pkg::DEPTH, 8'hFF, gbts_pkg::DEPTH - 1);
    issue_edit(gbts_pkg::OP_INSERT, 1'b0, 0, 8'h5A, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 2);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 3);
    issue_edit(gbts_pkg::OP_MOVE, 1'b1, 2, 8'h00, 0);
    // read past the gap
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 1);
    issue_edit(gbts_pkg::OP_INSERT, 1'b0, 0, 8'h81, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 2);
    issue_edit(gbts_pkg::OP_MOVE, 1'b0, 3, 8'h00, 0);
    issue_edit(gbts_pkg::OP_MOVE, 1'b0, 2, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b0, 1, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b1, 1, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b1, 3, 8'h00, 0);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    int unsigned k;
    k = 0;
    while (text_len() < gbts_pkg::DEPTH) begin
      if (k % 200 == 199) issue_edit(gbts_pkg::OP_MOVE, 1'b1, $urandom_range(gap_lo), 8'h00, 0);
      if (k % 50 == 25) begin
        issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, $urandom_range(text_len() - 1));
      end
      issue_edit(gbts_pkg::OP_INSERT, 1'($urandom_range(1)), $urandom_range(gbts_pkg::DEPTH),
                 gbts_pkg::CH_W'($urandom), $urandom_range(gbts_pkg::DEPTH - 1));
      k++;
    end
    issue_edit(gbts_pkg::OP_INSERT, 1'b0, 0, 8'hC3, 0);
    issue_edit(gbts_pkg::OP_MOVE, 1'b0, gbts_pkg::DEPTH - gap_hi, 8'h00, 0);
    // whole text across the gap in both directions
    issue_edit(gbts_pkg::OP_MOVE, 1'b1, gbts_pkg::DEPTH, 8'h00, 0);
    issue_edit(gbts_pkg::OP_INSERT, 1'b1, 0, 8'h3C, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, gbts_pkg::DEPTH - 1);
    issue_edit(gbts_pkg::OP_MOVE, 1'b0, gbts_pkg::DEPTH, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b0, 1, 8'h00, 0);
    issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, $urandom_range(gbts_pkg::DEPTH - 1));
    issue_edit(gbts_pkg::OP_REMOVE, 1'b1, gbts_pkg::DEPTH, 8'h00, 0);
    issue_edit(gbts_pkg::OP_REMOVE, 1'b1, 1, 8'h00, 0);
    wait_drained();
  endtask

  task automatic test_random_edits(int unsigned n);
    int unsigned               pick;
    int unsigned               side;
    int unsigned               cnt;
    int unsigned               idx;
    logic                      bwd;
    logic [gbts_pkg::CH_W-1:0] ch;
    gbts_pkg::op_e             op;
    repeat (n) begin
      pick = $urandom_range(99);
      bwd  = 1'($urandom_range(1));
      side = bwd ? gap_lo : gbts_pkg::DEPTH - gap_hi;
      cnt  = $urandom_range(gbts_pkg::DEPTH);
      ch   = gbts_pkg::CH_W'($urandom);
      idx  = $urandom_range(gbts_pkg::DEPTH - 1);
      if (pick < 15) begin
        op = gbts_pkg::op_e'($urandom_range(3));
      end else if (pick < 52) begin
        op = gbts_pkg::OP_INSERT;
      end else if (pick < 62) begin
        op  = gbts_pkg::OP_REMOVE;
        cnt = edit_count(side, 2);
      end else if (pick < 80) begin
        op  = gbts_pkg::OP_MOVE;
        cnt = edit_count(side, 4);
      end else begin
        op  = gbts_pkg::OP_READ;
        idx = text_index();
      end
      issue_edit(op, bwd, cnt, ch, idx);
    end
    wait_drained();
  endtask

  // Hold the result side off while commands keep coming, so the input stalls.
  task automatic test_output_stall();
    hold_left = STALL_CYCLES;
    repeat (40) begin
      if ($urandom_range(1)) begin
        issue_edit(gbts_pkg::OP_INSERT, 1'b0, 0, gbts_pkg::CH_W'($urandom), 0);
      end else begin
        issue_edit(gbts_pkg::OP_READ, 1'b0, 0, 8'h00, text_index());
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 56;
    test_directed_edges();
    test_fill_to_capacity();
    test_random_edits(240);

    send_idle_pct = 56;
    recv_idle_pct = 10;
    test_random_edits(240);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_edits(240);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d result beats for %0d edit commands in %0d cycles",
             result_count, cmd_count, cycle_count);
    $display("Refusals: %0d on a full buffer, %0d out of range; %0d bytes moved across the gap",
             full_count, range_count, bytes_copied);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
